>>> design/assert_macros.svh
// Assertion macros shared by the converter's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_CLK(label, prop, msg)
`endif
`endif

>>> design/r2i_pkg.sv
// Types, constants and colour arithmetic shared by the RGB to I420 converter.
package r2i_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH   = 4096;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int COUNT_LIMIT = 4096;
    localparam int WIDTH_CAP   = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [CFG_DATA_W-1:0] WIDTH_MAX_EFF    = CFG_DATA_W'(WIDTH_CAP);
    localparam logic [CFG_DATA_W-1:0] HEIGHT_MAX_EFF   = CFG_DATA_W'(COUNT_LIMIT);

    // Luma coefficients.
    localparam logic [15:0] Y_COEF_R = 16'd66;
    localparam logic [15:0] Y_COEF_G = 16'd129;
    localparam logic [15:0] Y_COEF_B = 16'd25;
    localparam logic [15:0] Y_ROUND  = 16'd128;
    localparam logic [8:0]  Y_OFFSET = 9'd16;
    localparam logic [8:0]  Y_MAX    = 9'd235;

    // Chroma coefficients.
    localparam logic signed [17:0] CB_R  = -18'sd38;
    localparam logic signed [17:0] CB_G  = -18'sd74;
    localparam logic signed [17:0] CB_B  = 18'sd112;
    localparam logic signed [17:0] CR_R  = 18'sd112;
    localparam logic signed [17:0] CR_G  = -18'sd94;
    localparam logic signed [17:0] CR_B  = -18'sd18;
    localparam logic signed [17:0] C_ROUND  = 18'sd128;
    localparam logic signed [17:0] C_OFFSET = 18'sd128;
    localparam logic signed [17:0] C_TRUNC  = 18'sd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  luma;
        logic [11:0] col_pos;
        logic [11:0] row_pos;
        logic        chroma_valid;
        logic [7:0]  cb_sample;
        logic [7:0]  cr_sample;
        logic        frame_end;
    } result_t;

    // Horizontal pair sums of one component triple; one line store entry.
    typedef struct packed {
        logic [8:0] sum_r;
        logic [8:0] sum_g;
        logic [8:0] sum_b;
    } pair_sum_t;

    // What the front end hands to the pipeline for one accepted pixel.
    typedef struct packed {
        logic [7:0]  luma;
        logic [11:0] col_pos;
        logic [11:0] row_pos;
        logic        block_done;
        logic        frame_end;
        pair_sum_t   pairs;
    } front_info_t;

    // Line store access for one accepted pixel.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [LINE_AW-1:0] addr;
        pair_sum_t          wdata;
    } line_req_t;

    // Divide by 256 with truncation toward zero, add the offset, clamp to a byte.
    function automatic logic [7:0] chroma_scale(input logic signed [17:0] acc);
        logic signed [17:0] biased;
        logic signed [17:0] shifted;
        logic signed [17:0] offset;
        biased  = (acc < 0) ? acc + C_TRUNC : acc;
        shifted = biased >>> 8;
        offset  = shifted + C_OFFSET;
        if (offset < 0) begin
            return 8'd0;
        end else if (offset > 18'sd255) begin
            return 8'd255;
        end
        return offset[7:0];
    endfunction

    function automatic logic [7:0] cb_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        logic signed [17:0] acc;
        acc = CB_R * signed'({10'd0, r}) + CB_G * signed'({10'd0, g})
            + CB_B * signed'({10'd0, b}) + C_ROUND;
        return chroma_scale(acc);
    endfunction

    function automatic logic [7:0] cr_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        logic signed [17:0] acc;
        acc = CR_R * signed'({10'd0, r}) + CR_G * signed'({10'd0, g})
            + CR_B * signed'({10'd0, b}) + C_ROUND;
        return chroma_scale(acc);
    endfunction

endpackage

>>> design/r2i_line_ram.sv
// Single-port synchronous RAM with registered read data, used as the line store.
module r2i_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 27
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/r2i_front.sv
// Front end: configuration registers, pixel position counters, luma and pair sums.
`include "assert_macros.svh"

module r2i_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  r2i_pkg::pixel_t                     pix,
    input  logic                                accept,
    input  logic                                cfg_valid,
    input  logic [r2i_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [r2i_pkg::CFG_DATA_W-1:0]      cfg_data,
    output r2i_pkg::front_info_t                info,
    output r2i_pkg::line_req_t                  line_req
);
    import r2i_pkg::*;

    logic [CFG_DATA_W-1:0] frame_width_reg,  frame_width_next;
    logic [CFG_DATA_W-1:0] frame_height_reg, frame_height_next;
    logic [11:0]           col_count_reg,    col_count_next;
    logic [11:0]           row_count_reg,    row_count_next;
    pixel_t                held_left_reg,    held_left_next;

    logic [CFG_DATA_W-1:0] width_eff;
    logic [CFG_DATA_W-1:0] height_eff;
    logic                  row_end;
    logic                  frame_last;
    logic [15:0]           luma_acc;
    logic [8:0]            luma_wide;
    logic                  odd_col;
    logic                  odd_row;
    pair_sum_t             pairs;

    // Configuration writes.
    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                CFG_FRAME_HEIGHT: frame_height_next = cfg_data;
            endcase
        end
    end

    // A zero size acts as one; oversized values saturate.
    always_comb begin
        if (frame_width_reg == '0) begin
            width_eff = CFG_DATA_W'(1);
        end else if (frame_width_reg > WIDTH_MAX_EFF) begin
            width_eff = WIDTH_MAX_EFF;
        end else begin
            width_eff = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            height_eff = CFG_DATA_W'(1);
        end else if (frame_height_reg > HEIGHT_MAX_EFF) begin
            height_eff = HEIGHT_MAX_EFF;
        end else begin
            height_eff = frame_height_reg;
        end
    end

    // Row and frame ends; a counter already past a shrunken size ends the row too.
    assign row_end    = ({1'b0, col_count_reg} + CFG_DATA_W'(1)) >= width_eff;
    assign frame_last = row_end && (({1'b0, row_count_reg} + CFG_DATA_W'(1)) >= height_eff);

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        held_left_next = held_left_reg;
        if (accept) begin
            if (row_end) begin
                col_count_next = '0;
                row_count_next = frame_last ? 12'd0 : row_count_reg + 12'd1;
            end else begin
                col_count_next = col_count_reg + 12'd1;
            end
            if (!odd_col) begin
                held_left_next = pix;
            end
        end
    end

    // Luma from constant coefficients; the clamp guards the upper limit.
    assign luma_acc = 16'(pix.red) * Y_COEF_R + 16'(pix.green) * Y_COEF_G
                    + 16'(pix.blue) * Y_COEF_B + Y_ROUND;
    assign luma_wide = 9'(luma_acc[15:8]) + Y_OFFSET;

    // Horizontal pair sums of the held even-column pixel and this one.
    assign pairs.sum_r = 9'(held_left_reg.red)   + 9'(pix.red);
    assign pairs.sum_g = 9'(held_left_reg.green) + 9'(pix.green);
    assign pairs.sum_b = 9'(held_left_reg.blue)  + 9'(pix.blue);

    assign odd_col = col_count_reg[0];
    assign odd_row = row_count_reg[0];

    always_comb begin
        info.luma       = (luma_wide > Y_MAX) ? Y_MAX[7:0] : luma_wide[7:0];
        info.col_pos    = col_count_reg;
        info.row_pos    = row_count_reg;
        info.block_done = odd_col && odd_row;
        info.frame_end  = frame_last;
        info.pairs      = pairs;
    end

    // Even rows store their pair sums; odd rows fetch them to finish the block.
    // The entry read on an odd row was written a whole row earlier, so no
    // access in flight ever touches the same entry.
    always_comb begin
        line_req.wr_en = accept && odd_col && !odd_row;
        line_req.rd_en = accept && odd_col && odd_row;
        line_req.addr  = LINE_AW'(col_count_reg >> 1);
        line_req.wdata = pairs;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            held_left_reg    <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_count_reg    <= col_count_next;
            row_count_reg    <= row_count_next;
            held_left_reg    <= held_left_next;
        end
    end

    `ASSERT_RST(a_line_one_access, !(line_req.wr_en && line_req.rd_en), "line store written and read in one cycle")
    `ASSERT_RST(a_col_in_row, (!accept || row_end || col_count_next != 12'd0) || (col_count_reg == 12'hFFF), "column counter wrapped before the row end")

endmodule

>>> design/rgba_to_i420_converter.sv
// Top level of the streaming RGB to limited-range BT.601 4:2:0 converter.
//
//  Channel  Ports                          Beat
//  input    s_valid, s_ready, s_data       one RGB pixel, raster order
//  result   m_valid, m_ready, m_data       luma, position, chroma when a 2x2 block completes
//  config   cfg_valid, cfg_ready, cfg_*    register index and write data
//
// One pixel per clock is accepted while s_ready is high, and its result is registered.
// The line store's single port is used at most once per pixel, on odd columns only.
// Reset is synchronous and active low; the line store needs no clearing pass,
// as each entry is written on an even row before an odd row reads it.
// A stall on the result side fills the three pipeline stages, then lowers s_ready.
// Configuration writes are taken on every cycle.
`include "assert_macros.svh"

module rgba_to_i420_converter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  r2i_pkg::pixel_t                  s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output r2i_pkg::result_t                 m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [r2i_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [r2i_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import r2i_pkg::*;

    front_info_t front_info;
    line_req_t   line_req;
    logic [$bits(pair_sum_t)-1:0] line_rdata;
    pair_sum_t   line_entry;

    logic accept;
    logic out_free, s2_free, s1_free;

    // Stage one: pixel info while the line store read completes.
    logic        s1_valid_reg, s1_valid_next;
    front_info_t s1_info_reg;

    // Stage two: finished 2x2 averages.
    logic        s2_valid_reg, s2_valid_next;
    front_info_t s2_info_reg;
    logic [7:0]  s2_avg_r_reg, s2_avg_g_reg, s2_avg_b_reg;
    logic [9:0]  quad_r, quad_g, quad_b;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    result_t     m_data_reg, m_data_next;

    r2i_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix       (s_data),
        .accept    (accept),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .info      (front_info),
        .line_req  (line_req)
    );

    r2i_line_ram #(
        .DEPTH (LINE_DEPTH),
        .WIDTH ($bits(pair_sum_t))
    ) u_line_ram (
        .aclk  (aclk),
        .wr_en (line_req.wr_en),
        .rd_en (line_req.rd_en),
        .addr  (line_req.addr),
        .wdata (line_req.wdata),
        .rdata (line_rdata)
    );

    assign line_entry = pair_sum_t'(line_rdata);

    // Pipeline flow: a stage moves on when the one after it is empty or moving.
    // The read data holds while stage one stalls, as no new pixel is accepted.
    assign out_free  = !m_valid_reg || m_ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign s_ready   = s1_free;
    assign accept    = s_valid && s1_free;
    assign cfg_ready = 1'b1;

    assign s1_valid_next = s1_free  ? accept       : s1_valid_reg;
    assign s2_valid_next = s2_free  ? s1_valid_reg : s2_valid_reg;
    assign m_valid_next  = out_free ? s2_valid_reg : m_valid_reg;

    // Vertical sums of the two rows' pair sums; stage two stores them floored by four.
    assign quad_r = 10'(s1_info_reg.pairs.sum_r) + 10'(line_entry.sum_r);
    assign quad_g = 10'(s1_info_reg.pairs.sum_g) + 10'(line_entry.sum_g);
    assign quad_b = 10'(s1_info_reg.pairs.sum_b) + 10'(line_entry.sum_b);

    // Result assembly; chroma fields stay zero unless a block completes.
    always_comb begin
        m_data_next.luma         = s2_info_reg.luma;
        m_data_next.col_pos      = s2_info_reg.col_pos;
        m_data_next.row_pos      = s2_info_reg.row_pos;
        m_data_next.chroma_valid = s2_info_reg.block_done;
        m_data_next.frame_end    = s2_info_reg.frame_end;
        if (s2_info_reg.block_done) begin
            m_data_next.cb_sample = cb_of(s2_avg_r_reg, s2_avg_g_reg, s2_avg_b_reg);
            m_data_next.cr_sample = cr_of(s2_avg_r_reg, s2_avg_g_reg, s2_avg_b_reg);
        end else begin
            m_data_next.cb_sample = '0;
            m_data_next.cr_sample = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg <= front_info;
        end
        if (s1_valid_reg && s2_free) begin
            s2_info_reg  <= s1_info_reg;
            s2_avg_r_reg <= quad_r[9:2];
            s2_avg_g_reg <= quad_g[9:2];
            s2_avg_b_reg <= quad_b[9:2];
        end
        if (s2_valid_reg && out_free) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_RST(a_chroma_odd_pos, !(m_valid && m_data.chroma_valid) || (m_data.col_pos[0] && m_data.row_pos[0]), "chroma given outside an odd row and odd column")
    `ASSERT_RST(a_chroma_zero, !(m_valid && !m_data.chroma_valid) || (m_data.cb_sample == 8'd0 && m_data.cr_sample == 8'd0), "chroma fields not zero without a completed block")
    `ASSERT_RST(a_s1_holds, (s1_valid_reg && !s2_free) |=> (s1_valid_reg && s1_info_reg == $past(s1_info_reg)), "stage one lost or changed a stalled pixel")
    `ASSERT_CLK(a_reset_empty, !aresetn |=> (!m_valid_reg && !s1_valid_reg && !s2_valid_reg), "pipeline not empty after reset")

endmodule

>>> verif/tb_rgba_to_i420_converter.sv
// Self-checking testbench for the streaming RGB to limited-range BT.601 4:2:0 converter.
module tb_rgba_to_i420_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import r2i_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int STALL_CYCLES     = 300;
    localparam int RANDOM_PER_PHASE = 370;
    localparam int DRAIN_CYCLES     = 10;

    // One row of the directed sequence: an optional frame size change before the beat,
    // the pixel itself and, where it is obvious, the result typed in by hand.
    typedef struct packed {
        logic        set_size;
        logic [12:0] w;
        logic [12:0] h;
        pixel_t      px;
        logic        typed;
        result_t     res;
    } step_t;

    localparam pixel_t  WHITE_PX  = {8'd255, 8'd255, 8'd255};
    localparam pixel_t  BLUE_PX   = {8'd0, 8'd0, 8'd255};
    localparam pixel_t  RED_PX    = {8'd255, 8'd0, 8'd0};
    localparam result_t NO_RESULT = '0;

    localparam step_t DIRECTED [27] = '{
        // Saturated 2x2 frames: grey gives neutral chroma, pure blue and red hit the
        // negative truncation toward zero.
        {1'b1, 13'd2, 13'd2, WHITE_PX, 1'b1, {8'd235, 12'd0, 12'd0, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, WHITE_PX, 1'b1, {8'd235, 12'd1, 12'd0, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, WHITE_PX, 1'b1, {8'd235, 12'd0, 12'd1, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, WHITE_PX, 1'b1,
            {8'd235, 12'd1, 12'd1, 1'b1, 8'd128, 8'd128, 1'b1}},
        {1'b0, 13'd2, 13'd2, BLUE_PX, 1'b1, {8'd41, 12'd0, 12'd0, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, BLUE_PX, 1'b1, {8'd41, 12'd1, 12'd0, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, BLUE_PX, 1'b1, {8'd41, 12'd0, 12'd1, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, BLUE_PX, 1'b1, {8'd41, 12'd1, 12'd1, 1'b1, 8'd240, 8'd111, 1'b1}},
        {1'b0, 13'd2, 13'd2, RED_PX, 1'b1, {8'd82, 12'd0, 12'd0, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, RED_PX, 1'b1, {8'd82, 12'd1, 12'd0, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, RED_PX, 1'b1, {8'd82, 12'd0, 12'd1, 1'b0, 8'd0, 8'd0, 1'b0}},
        {1'b0, 13'd2, 13'd2, RED_PX, 1'b1, {8'd82, 12'd1, 12'd1, 1'b1, 8'd91, 8'd240, 1'b1}},
        // Zero width and height act as one: every pixel is a frame of its own.
        {1'b1, 13'd0, 13'd0, {8'd255, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        {1'b0, 13'd0, 13'd0, {8'd0, 8'd255, 8'd0}, 1'b0, NO_RESULT},
        // Trailing odd column gets luma only.
        {1'b1, 13'd3, 13'd2, {8'd17, 8'd200, 8'd3}, 1'b0, NO_RESULT},
        {1'b0, 13'd3, 13'd2, {8'd128, 8'd127, 8'd1}, 1'b0, NO_RESULT},
        {1'b0, 13'd3, 13'd2, {8'd90, 8'd60, 8'd250}, 1'b0, NO_RESULT},
        {1'b0, 13'd3, 13'd2, {8'd1, 8'd254, 8'd77}, 1'b0, NO_RESULT},
        {1'b0, 13'd3, 13'd2, {8'd64, 8'd32, 8'd16}, 1'b0, NO_RESULT},
        {1'b0, 13'd3, 13'd2, {8'd255, 8'd128, 8'd0}, 1'b0, NO_RESULT},
        // Width shrinks below the column in mid-row, then the height below the row.
        {1'b1, 13'd6, 13'd4, {8'd200, 8'd10, 8'd30}, 1'b0, NO_RESULT},
        {1'b0, 13'd6, 13'd4, {8'd5, 8'd250, 8'd99}, 1'b0, NO_RESULT},
        {1'b0, 13'd6, 13'd4, {8'd33, 8'd66, 8'd132}, 1'b0, NO_RESULT},
        {1'b1, 13'd2, 13'd4, {8'd77, 8'd88, 8'd99}, 1'b0, NO_RESULT},
        {1'b0, 13'd2, 13'd4, {8'd150, 8'd0, 8'd75}, 1'b0, NO_RESULT},
        {1'b0, 13'd2, 13'd4, {8'd0, 8'd180, 8'd255}, 1'b0, NO_RESULT},
        {1'b1, 13'd1, 13'd1, {8'd123, 8'd45, 8'd67}, 1'b0, NO_RESULT}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pixel_t                s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    result_t               m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Own copy of the converter state, kept in step with every accepted beat.
    logic [12:0] width_setting  = FRAME_WIDTH_RST;
    logic [12:0] height_setting = FRAME_HEIGHT_RST;
    int unsigned col_ctr        = 0;
    int unsigned row_ctr        = 0;
    pixel_t      held_left      = '0;
    pair_sum_t   pair_line [LINE_DEPTH];

    result_t     expected_yuv [$];
    logic        last_frame_end = 1'b0;
    int unsigned pixels_sent    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    bit          stall_request  = 1'b0;

    rgba_to_i420_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A register value of zero means one; anything above the cap saturates.
    function automatic int unsigned effective_size(input logic [12:0] setting,
                                                   input int unsigned cap);
        if (setting == 13'd0) begin
            return 1;
        end
        return (setting > cap) ? cap : setting;
    endfunction

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // Works out the result of one pixel and advances the position counters.
    function automatic result_t convert_pixel(input pixel_t px);
        result_t     res;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned yy;
        int unsigned idx;
        int          sr;
        int          sg;
        int          sb;
        pair_sum_t   pair;
        pair_sum_t   above;
        logic        row_end;
        res   = '0;
        w_eff = effective_size(width_setting, WIDTH_CAP);
        h_eff = effective_size(height_setting, COUNT_LIMIT);
        yy = ((66 * px.red + 129 * px.green + 25 * px.blue + 128) >> 8) + 16;
        if (yy > 235) begin
            yy = 235;
        end
        res.luma    = yy[7:0];
        res.col_pos = col_ctr[11:0];
        res.row_pos = row_ctr[11:0];

        // Odd column: the horizontal pair is complete. Even rows store it, odd rows
        // combine it with the stored pair above to finish the 2x2 block.
        if (col_ctr[0]) begin
            pair.sum_r = {1'b0, held_left.red} + px.red;
            pair.sum_g = {1'b0, held_left.green} + px.green;
            pair.sum_b = {1'b0, held_left.blue} + px.blue;
            idx = col_ctr >> 1;
            if (idx < LINE_DEPTH) begin
                if (!row_ctr[0]) begin
                    pair_line[idx] = pair;
                end else begin
                    above = pair_line[idx];
                    sr = (int'(pair.sum_r) + int'(above.sum_r)) >>> 2;
                    sg = (int'(pair.sum_g) + int'(above.sum_g)) >>> 2;
                    sb = (int'(pair.sum_b) + int'(above.sum_b)) >>> 2;
                    res.cb_sample    = clamp_byte((-38 * sr - 74 * sg + 112 * sb + 128) / 256
                                                  + 128);
                    res.cr_sample    = clamp_byte((112 * sr - 94 * sg - 18 * sb + 128) / 256
                                                  + 128);
                    res.chroma_valid = 1'b1;
                end
            end
        end else begin
            held_left = px;
        end

        row_end       = (col_ctr + 1) >= w_eff;
        res.frame_end = row_end && ((row_ctr + 1) >= h_eff);
        if (row_end) begin
            col_ctr = 0;
            row_ctr = res.frame_end ? 0 : ((row_ctr + 1) & 12'hFFF);
        end else begin
            col_ctr = (col_ctr + 1) & 12'hFFF;
        end
        return res;
    endfunction

    // Extremes of each component turn up often, the rest is uniform.
    function automatic pixel_t random_pixel();
        logic [7:0] comp [3];
        foreach (comp[i]) begin
            case ($urandom_range(7))
                0:       comp[i] = 8'd0;
                1:       comp[i] = 8'd255;
                default: comp[i] = 8'($urandom_range(255));
            endcase
        end
        return {comp[0], comp[1], comp[2]};
    endfunction

    // Offers one pixel beat after an optional random gap and records its expectation.
    task automatic send_pixel(input pixel_t px, input logic use_typed, input result_t typed_res);
        result_t predicted;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        predicted = convert_pixel(px);
        expected_yuv.push_back(use_typed ? typed_res : predicted);
        last_frame_end = predicted.frame_end;
        pixels_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == CFG_FRAME_WIDTH) begin
            width_setting = value;
        end else begin
            height_setting = value;
        end
    endtask

    // Size changes only go in once the pipeline has handed back every result.
    task automatic set_frame_size(input logic [12:0] w_set, input logic [12:0] h_set);
        s_valid <= 1'b0;
        while (expected_yuv.size() != 0) @(posedge aclk);
        write_register(CFG_FRAME_WIDTH, w_set);
        write_register(CFG_FRAME_HEIGHT, h_set);
        cfg_valid <= 1'b0;
    endtask

    // A small frame of random pixels. Now and then the frame is cut in the middle by
    // a width no wider than before and a new height; the width never grows mid-frame, so odd rows
    // only read pair sums that the row above has written.
    task automatic run_random_frame();
        logic [12:0] w_set;
        logic [12:0] h_set;
        int unsigned area;
        int unsigned cut_at;
        int unsigned count;
        case ($urandom_range(9))
            0:       w_set = 13'd0;
            1:       w_set = 13'd1;
            2:       w_set = 13'd2;
            default: w_set = 13'($urandom_range(1, 24));
        endcase
        case ($urandom_range(9))
            0:       h_set = 13'd0;
            1:       h_set = 13'd1;
            default: h_set = 13'($urandom_range(1, 6));
        endcase
        set_frame_size(w_set, h_set);
        area   = effective_size(w_set, WIDTH_CAP) * effective_size(h_set, COUNT_LIMIT);
        cut_at = (area > 1 && $urandom_range(3) == 0) ? $urandom_range(1, area - 1) : 0;
        count  = 0;
        do begin
            send_pixel(random_pixel(), 1'b0, NO_RESULT);
            count++;
            if (count == cut_at && !last_frame_end) begin
                set_frame_size(13'($urandom_range(0, effective_size(width_setting, WIDTH_CAP))),
                               13'($urandom_range(0, 6)));
            end
        end while (!last_frame_end);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_request = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every result beat is checked against the oldest expectation.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_yuv.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result beat expected none, actual %h", $time, m_data);
            end else begin
                want = expected_yuv.pop_front();
                compare_field("luma", want.luma, m_data.luma);
                compare_field("col_pos", want.col_pos, m_data.col_pos);
                compare_field("row_pos", want.row_pos, m_data.row_pos);
                compare_field("chroma_valid", want.chroma_valid, m_data.chroma_valid);
                compare_field("cb_sample", want.cb_sample, m_data.cb_sample);
                compare_field("cr_sample", want.cr_sample, m_data.cr_sample);
                compare_field("frame_end", want.frame_end, m_data.frame_end);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned phase_start;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender mostly busy, receiver mostly stalled.
        tx_idle_pct = 21;
        rx_idle_pct = 79;
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].set_size) begin
                set_frame_size(DIRECTED[i].w, DIRECTED[i].h);
            end
            send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].res);
        end
        phase_start = pixels_sent;
        while (pixels_sent - phase_start < RANDOM_PER_PHASE) run_random_frame();

        // The other way round.
        tx_idle_pct = 79;
        rx_idle_pct = 21;
        phase_start = pixels_sent;
        while (pixels_sent - phase_start < RANDOM_PER_PHASE) run_random_frame();

        // Full rate, opening with a long hold-off over a 16x4 frame, so the pipeline
        // fills and s_ready drops while the sender keeps offering pixels.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase_start = pixels_sent;
        set_frame_size(13'd16, 13'd4);
        stall_request = 1'b1;
        do send_pixel(random_pixel(), 1'b0, NO_RESULT); while (!last_frame_end);
        while (pixels_sent - phase_start < RANDOM_PER_PHASE) run_random_frame();

        // Oversized width saturates; the row is then cut short by a narrow width.
        set_frame_size(13'd8191, 13'd2);
        repeat (6) send_pixel(random_pixel(), 1'b0, NO_RESULT);
        set_frame_size(13'd3, 13'd1);
        do send_pixel(random_pixel(), 1'b0, NO_RESULT); while (!last_frame_end);
        // Zero width with oversized height: one pixel per row until the height shrinks.
        set_frame_size(13'd0, 13'd8191);
        repeat (5) send_pixel(random_pixel(), 1'b0, NO_RESULT);
        set_frame_size(13'd1, 13'd1);
        do send_pixel(random_pixel(), 1'b0, NO_RESULT); while (!last_frame_end);
        // Largest legal sizes, cut short after a few pixels.
        set_frame_size(13'd4096, 13'd4096);
        repeat (5) send_pixel(random_pixel(), 1'b0, NO_RESULT);
        set_frame_size(13'd3, 13'd1);
        do send_pixel(random_pixel(), 1'b0, NO_RESULT); while (!last_frame_end);

        s_valid <= 1'b0;
        while (expected_yuv.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_yuv.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
